### hdl/temp_triggered_motor_sequencer_unit_defines.svh
// assertion helpers for the sequencer top level
`ifndef TEMP_TRIGGERED_MOTOR_SEQUENCER_UNIT_DEFINES_SVH
`define TEMP_TRIGGERED_MOTOR_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TTMS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ttms check failed");

// next-cycle implication
`define TTMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ttms check failed");

`endif

### hdl/ttms_pkg.sv
`default_nettype none
package ttms_pkg;

	localparam int TEMP_W = 12;
	localparam int TICK_W = 21;
	localparam int PHASE_W = 3;
	localparam int TIME_W = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
	localparam logic [PHASE_W-1:0] PH_M2 = 3'd1;
	localparam logic [PHASE_W-1:0] PH_WAIT = 3'd2;
	localparam logic [PHASE_W-1:0] PH_M1 = 3'd3;
	localparam logic [PHASE_W-1:0] PH_COOL = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_RUN_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TICKS = 2'd3;

	localparam logic signed [TEMP_W-1:0] TEMP_LOW_EXCL = -12'sd1600;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH_EXCL = 12'sd1600;

	localparam logic signed [TEMP_W-1:0] RST_START_LEVEL = 12'sd192;
	localparam logic [TICK_W-1:0] RST_MOTOR_RUN_TICKS = 21'd5000;
	localparam logic [TICK_W-1:0] RST_GAP_TICKS = 21'd2000;
	localparam logic [TICK_W-1:0] RST_COOLDOWN_TICKS = 21'd1200000;

	localparam int MS_PER_MIN = 60000;
	localparam int MS_PER_SEC = 1000;
	// floor(2^30 / 60000) and floor(2^20 / 1000): quotient low by at most one
	localparam int RECIP_MIN = 17895;
	localparam int RECIP_SEC = 1048;

	typedef struct packed {
		logic signed [TEMP_W-1:0] start_level;
		logic [TICK_W-1:0] motor_run_ticks;
		logic [TICK_W-1:0] gap_ticks;
		logic [TICK_W-1:0] cooldown_ticks;
	} cfg_t;

	typedef struct packed {
		logic motor_one_on;
		logic motor_two_on;
		logic [PHASE_W-1:0] phase_now;
		logic signed [TEMP_W-1:0] temp_latched;
		logic temp_known;
	} res_t;

	typedef struct packed {
		res_t res;
		logic [TICK_W-1:0] rem;
	} seq_rec_t;

endpackage
`default_nettype wire

### hdl/ttms_if.sv
`default_nettype none
interface ttms_in_if import ttms_pkg::*; ();
	logic valid;
	logic ready;
	logic sample_present;
	logic signed [TEMP_W-1:0] temp_sample;
	modport source(output valid, output sample_present, output temp_sample, input ready);
	modport sink(input valid, input sample_present, input temp_sample, output ready);
endinterface

interface ttms_out_if import ttms_pkg::*; ();
	logic valid;
	logic ready;
	logic motor_one_on;
	logic motor_two_on;
	logic [PHASE_W-1:0] phase_now;
	logic signed [TEMP_W-1:0] temp_latched;
	logic temp_known;
	logic [TIME_W-1:0] minutes_left;
	logic [TIME_W-1:0] seconds_left;
	modport source(output valid, output motor_one_on, output motor_two_on, output phase_now,
		output temp_latched, output temp_known, output minutes_left, output seconds_left,
		input ready);
	modport sink(input valid, input motor_one_on, input motor_two_on, input phase_now,
		input temp_latched, input temp_known, input minutes_left, input seconds_left,
		output ready);
endinterface

interface ttms_cfg_if import ttms_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TICK_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/ttms_cfg_regs.sv
`default_nettype none
module ttms_cfg_regs import ttms_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	ttms_cfg_if.sink cfg_req,
	output cfg_t cfg
);

	cfg_t cfg_q;

	assign cfg_req.ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_level <= RST_START_LEVEL;
			cfg_q.motor_run_ticks <= RST_MOTOR_RUN_TICKS;
			cfg_q.gap_ticks <= RST_GAP_TICKS;
			cfg_q.cooldown_ticks <= RST_COOLDOWN_TICKS;
		end else if (cfg_req.valid) begin
			unique case (cfg_req.index)
				CFG_START_LEVEL: cfg_q.start_level <= cfg_req.data[TEMP_W-1:0];
				CFG_MOTOR_RUN_TICKS: cfg_q.motor_run_ticks <= cfg_req.data;
				CFG_GAP_TICKS: cfg_q.gap_ticks <= cfg_req.data;
				CFG_COOLDOWN_TICKS: cfg_q.cooldown_ticks <= cfg_req.data;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/ttms_seq_core.sv
`default_nettype none
module ttms_seq_core import ttms_pkg::*; #(
	parameter int TIMER_BITS = 21
) (
	input wire logic clk,
	input wire logic arst_n,
	ttms_in_if.sink in_req,
	input wire cfg_t cfg,
	output logic rec_valid,
	input wire logic rec_ready,
	output seq_rec_t rec
);

	localparam int CW = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

	// input register
	logic v_s1;
	logic sp_s1;
	logic signed [TEMP_W-1:0] ts_s1;

	// sequencer state
	logic [PHASE_W-1:0] phase_q, phase_n, next_ph;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_n, elapsed_inc;
	logic signed [TEMP_W-1:0] temp_q, temp_n;
	logic known_q, known_n;
	logic timed;
	logic [TICK_W-1:0] limit, rem;
	logic [CW-1:0] inc_x, lim_x, el_x, cool_x;

	logic v_s2;
	seq_rec_t rec_s2;
	logic rdy_s2, step;

	assign rdy_s2 = !v_s2 || rec_ready;
	assign step = v_s1 && rdy_s2;
	assign in_req.ready = !v_s1 || rdy_s2;
	assign rec_valid = v_s2;
	assign rec = rec_s2;

	always_comb begin
		temp_n = temp_q;
		known_n = known_q;
		if (sp_s1 && (ts_s1 > TEMP_LOW_EXCL) && (ts_s1 < TEMP_HIGH_EXCL)) begin
			temp_n = ts_s1;
			known_n = 1'b1;
		end

		elapsed_inc = (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + 1'b1;
		timed = 1'b1;
		unique case (phase_q)
			PH_M2: begin
				limit = cfg.motor_run_ticks;
				next_ph = PH_WAIT;
			end
			PH_WAIT: begin
				limit = cfg.gap_ticks;
				next_ph = PH_M1;
			end
			PH_M1: begin
				limit = cfg.motor_run_ticks;
				next_ph = PH_COOL;
			end
			PH_COOL: begin
				limit = cfg.cooldown_ticks;
				next_ph = PH_IDLE;
			end
			default: begin
				timed = 1'b0;
				limit = '0;
				next_ph = PH_IDLE;
			end
		endcase

		inc_x = CW'(elapsed_inc);
		lim_x = CW'(limit);
		phase_n = phase_q;
		elapsed_n = elapsed_q;
		if (timed) begin
			elapsed_n = elapsed_inc;
			if (inc_x >= lim_x) begin
				phase_n = next_ph;
				elapsed_n = '0;
			end
		end else begin
			phase_n = PH_IDLE;
			if (known_n && (temp_n > cfg.start_level)) begin
				phase_n = PH_M2;
				elapsed_n = '0;
			end
		end

		el_x = CW'(elapsed_n);
		cool_x = CW'(cfg.cooldown_ticks);
		rem = '0;
		if ((phase_n == PH_COOL) && (el_x < cool_x))
			rem = TICK_W'(cool_x - el_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			phase_q <= PH_IDLE;
			elapsed_q <= '0;
			temp_q <= '0;
			known_q <= 1'b0;
		end else begin
			if (in_req.ready)
				v_s1 <= in_req.valid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (step) begin
				phase_q <= phase_n;
				elapsed_q <= elapsed_n;
				temp_q <= temp_n;
				known_q <= known_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_req.valid && in_req.ready) begin
			sp_s1 <= in_req.sample_present;
			ts_s1 <= in_req.temp_sample;
		end
		if (step) begin
			rec_s2.res.motor_one_on <= (phase_n == PH_M1);
			rec_s2.res.motor_two_on <= (phase_n == PH_M2);
			rec_s2.res.phase_now <= phase_n;
			rec_s2.res.temp_latched <= temp_n;
			rec_s2.res.temp_known <= known_n;
			rec_s2.rem <= rem;
		end
	end

endmodule
`default_nettype wire

### hdl/ttms_time_split.sv
`default_nettype none
module ttms_time_split import ttms_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rec_valid,
	output logic rec_ready,
	input wire seq_rec_t rec,
	ttms_out_if.source out_res
);

	localparam int PM_W = 36;
	localparam int RM_W = 22;
	localparam int R_W = 16;
	localparam int PS_W = 26;

	logic v_s3, v_s4, v_s5, v_o;
	logic rdy_s3, rdy_s4, rdy_s5, rdy_o;

	res_t res_s3, res_s4, res_s5, res_o;
	logic [TICK_W-1:0] rem_s3;
	logic [TIME_W-1:0] q0_s3, min_s4, min_s5, min_o;
	logic [R_W-1:0] r_s4, r_s5;
	logic [TIME_W-1:0] s0_s5, sec_o;

	logic [PM_W-1:0] prod_min;
	logic [RM_W-1:0] prod_back, r_full;
	logic [TIME_W-1:0] min_c;
	logic [R_W-1:0] r_c;
	logic [PS_W-1:0] prod_sec;
	logic [R_W-1:0] prod_ms, rr;
	logic [TIME_W-1:0] sec_c;

	assign rdy_o = !v_o || out_res.ready;
	assign rdy_s5 = !v_s5 || rdy_o;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rec_ready = rdy_s3;

	always_comb begin
		prod_min = PM_W'(rec.rem) * PM_W'(RECIP_MIN);

		prod_back = RM_W'(q0_s3) * RM_W'(MS_PER_MIN);
		r_full = RM_W'(rem_s3) - prod_back;
		if (r_full >= RM_W'(MS_PER_MIN)) begin
			min_c = q0_s3 + 1'b1;
			r_c = R_W'(r_full - RM_W'(MS_PER_MIN));
		end else begin
			min_c = q0_s3;
			r_c = R_W'(r_full);
		end

		prod_sec = PS_W'(r_s4) * PS_W'(RECIP_SEC);

		prod_ms = R_W'(s0_s5) * R_W'(MS_PER_SEC);
		rr = r_s5 - prod_ms;
		sec_c = (rr >= R_W'(MS_PER_SEC)) ? s0_s5 + 1'b1 : s0_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_o <= 1'b0;
		end else begin
			if (rdy_s3)
				v_s3 <= rec_valid;
			if (rdy_s4)
				v_s4 <= v_s3;
			if (rdy_s5)
				v_s5 <= v_s4;
			if (rdy_o)
				v_o <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && rec_valid) begin
			res_s3 <= rec.res;
			rem_s3 <= rec.rem;
			q0_s3 <= prod_min[PM_W-1:PM_W-TIME_W];
		end
		if (rdy_s4 && v_s3) begin
			res_s4 <= res_s3;
			min_s4 <= min_c;
			r_s4 <= r_c;
		end
		if (rdy_s5 && v_s4) begin
			res_s5 <= res_s4;
			min_s5 <= min_s4;
			r_s5 <= r_s4;
			s0_s5 <= prod_sec[PS_W-1:PS_W-TIME_W];
		end
		if (rdy_o && v_s5) begin
			res_o <= res_s5;
			min_o <= min_s5;
			sec_o <= sec_c;
		end
	end

	assign out_res.valid = v_o;
	assign out_res.motor_one_on = res_o.motor_one_on;
	assign out_res.motor_two_on = res_o.motor_two_on;
	assign out_res.phase_now = res_o.phase_now;
	assign out_res.temp_latched = res_o.temp_latched;
	assign out_res.temp_known = res_o.temp_known;
	assign out_res.minutes_left = min_o;
	assign out_res.seconds_left = sec_o;

endmodule
`default_nettype wire

### hdl/temp_triggered_motor_sequencer_unit.sv
// channel   modport  moves
// in_req    sink     one millisecond tick, optional temperature sample
// out_res   source   motor drives, phase, latched temperature, cooldown time left
// cfg_req   sink     register write, index and data, always ready
//
// One request per cycle sustained while out_res is ready; each result is registered
// through the six-register chain: input register, sequencer step,
// then four stages of constant reciprocal division for minutes and seconds.
// Asynchronous active-low reset clears sequencer state and all valid flags; data registers are not reset.
// A stalled result holds its stage; ready runs combinationally back to in_req,
// so empty stages keep filling and a full chain stops in the same cycle.
`default_nettype none
`include "temp_triggered_motor_sequencer_unit_defines.svh"
module temp_triggered_motor_sequencer_unit import ttms_pkg::*; #(
	parameter int TIMER_BITS = 21
) (
	input wire logic clk,
	input wire logic arst_n,
	ttms_in_if.sink in_req,
	ttms_out_if.source out_res,
	ttms_cfg_if.sink cfg_req
);

	cfg_t cfg;
	logic rec_valid;
	logic rec_ready;
	seq_rec_t rec;

	ttms_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_req(cfg_req),
		.cfg(cfg)
	);

	ttms_seq_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_req(in_req),
		.cfg(cfg),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec(rec)
	);

	ttms_time_split u_split (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec(rec),
		.out_res(out_res)
	);

	`TTMS_ASSERT_NOW(a_motor_phase, out_res.valid, (out_res.motor_two_on == (out_res.phase_now == PH_M2)) && (out_res.motor_one_on == (out_res.phase_now == PH_M1)))
	`TTMS_ASSERT_NOW(a_time_idle, out_res.valid && (out_res.phase_now != PH_COOL), (out_res.minutes_left == '0) && (out_res.seconds_left == '0))
	`TTMS_ASSERT_NOW(a_sec_range, out_res.valid, out_res.seconds_left < 6'd60)
	`TTMS_ASSERT_NEXT(a_rec_hold, rec_valid && !rec_ready, rec_valid && $stable(rec))

endmodule
`default_nettype wire
